FILE: hdl/m4cm_pkg.sv
// shared types and constants for the 4x4 column matrix multiplier
`timescale 1ns / 1ps

package m4cm_pkg;

   localparam int DIM           = 4;
   localparam int ELEM_W        = 32;
   localparam int COL_W         = 2;
   localparam int PROD_W        = 2 * ELEM_W;
   localparam int PAIR_W        = PROD_W + 1;
   localparam int ACC_W         = PROD_W + 2;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic {
      MODE_LOAD     = 1'b0,
      MODE_MULTIPLY = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [COL_W-1:0]          column;
      logic signed [ELEM_W-1:0]  elem0;
      logic signed [ELEM_W-1:0]  elem1;
      logic signed [ELEM_W-1:0]  elem2;
      logic signed [ELEM_W-1:0]  elem3;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]          out_column;
      logic signed [ELEM_W-1:0]  out0;
      logic signed [ELEM_W-1:0]  out1;
      logic signed [ELEM_W-1:0]  out2;
      logic signed [ELEM_W-1:0]  out3;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } pipe_ctrl_type;

endpackage

FILE: hdl/m4cm_lane.sv
// one row lane: four products, adder tree, shift and saturation
`timescale 1ns / 1ps

module m4cm_lane
   import m4cm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  pipe_ctrl_type            ctrl,
   input  logic signed [ELEM_W-1:0] a_row [DIM],
   input  logic signed [ELEM_W-1:0] b_col [DIM],
   output logic signed [ELEM_W-1:0] res,
   output logic                     clip
);

   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [ACC_W-1:0]  sum_ff;
   logic signed [ACC_W-1:0]  sum_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [ACC_W-ELEM_W:0]    upper;

   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         prod_in[k] = a_row[k] * b_col[k];
      end
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      sum_in     = ACC_W'(pair_ff[0]) + ACC_W'(pair_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.en2) begin
         pair_ff <= pair_in;
      end
      if (ctrl.en3) begin
         sum_ff <= sum_in;
      end
   end

   // floor shift, then clip to the 32-bit range
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      upper   = shifted[ACC_W-1:ELEM_W-1];
      clip    = (upper != '0) && (upper != '1);
      if (!clip) begin
         res = shifted[ELEM_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         res = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

endmodule

FILE: hdl/m4cm_merge.sv
// merges the lane results into the response register
`timescale 1ns / 1ps

module m4cm_merge
   import m4cm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en_out,
   input  logic                     stage_valid,
   input  logic [COL_W-1:0]         stage_column,
   input  logic signed [ELEM_W-1:0] lane_res [DIM],
   input  logic [DIM-1:0]           lane_clip,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;

   always_comb begin
      out_valid_in           = en_out ? stage_valid : out_valid_ff;
      out_data_in.out_column = stage_column;
      out_data_in.out0       = lane_res[0];
      out_data_in.out1       = lane_res[1];
      out_data_in.out2       = lane_res[2];
      out_data_in.out3       = lane_res[3];
      out_data_in.saturated  = |lane_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (en_out && stage_valid) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: hdl/matrix4_column_multiply.sv
// top level: 4x4 matrix product, one right-matrix column per request
//
// usage
//   requests arrive on req_valid/req_ready/req_data. a load request (mode 0)
//   writes one column of the stored left matrix and gives no response. a
//   multiply request (mode 1) gives one response on rsp_valid/rsp_ready/
//   rsp_data: the matching column of the product, each element floor-shifted
//   by FRAC_BITS and clipped to 32 bits, with a saturated flag.
//   the response of a multiply request passes through the multiply, pair add,
//   final add and response registers in that order.
//   throughput, unless the full pipeline stalls: one request per cycle; each of
//   the four row lanes has its own four multipliers, so a column enters the
//   multiply stage every such cycle. a load takes effect for the next request
//   accepted. reset clears the left matrix to zero and empties the pipeline.
//   when the receiver stalls, the response holds and each pipeline stage
//   fills in turn; req_ready drops only once all stages hold a request.
`timescale 1ns / 1ps

module matrix4_column_multiply
   import m4cm_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic signed [ELEM_W-1:0] left_ff [DIM*DIM];
   logic signed [ELEM_W-1:0] elem_arr [DIM];
   logic signed [ELEM_W-1:0] a_rows [DIM][DIM];
   logic signed [ELEM_W-1:0] lane_res [DIM];
   logic [DIM-1:0]           lane_clip;

   logic             v1_ff, v2_ff, v3_ff;
   logic             v1_in, v2_in, v3_in;
   logic [COL_W-1:0] col1_ff, col2_ff, col3_ff;
   logic             en_out;
   logic             accept;
   logic             load_req;
   pipe_ctrl_type    ctrl;

   assign elem_arr[0] = req_data.elem0;
   assign elem_arr[1] = req_data.elem1;
   assign elem_arr[2] = req_data.elem2;
   assign elem_arr[3] = req_data.elem3;

   // bubble-collapsing enables
   always_comb begin
      en_out    = !rsp_valid || rsp_ready;
      ctrl.en3  = !v3_ff || en_out;
      ctrl.en2  = !v2_ff || ctrl.en3;
      ctrl.en1  = !v1_ff || ctrl.en2;
      req_ready = ctrl.en1;
      accept    = req_valid && req_ready;
      load_req  = accept && (req_data.mode == MODE_LOAD);
      v1_in     = ctrl.en1 ? (accept && (req_data.mode == MODE_MULTIPLY)) : v1_ff;
      v2_in     = ctrl.en2 ? v1_ff : v2_ff;
      v3_in     = ctrl.en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i < DIM*DIM; i++) begin
            left_ff[i] <= '0;
         end
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         for (int i = 0; i < DIM*DIM; i++) begin
            if (load_req && (req_data.column == i[3:2])) begin
               left_ff[i] <= elem_arr[i[1:0]];
            end
         end
      end
      if (ctrl.en1) begin
         col1_ff <= req_data.column;
      end
      if (ctrl.en2) begin
         col2_ff <= col1_ff;
      end
      if (ctrl.en3) begin
         col3_ff <= col2_ff;
      end
   end

   // entry column*4+row feeds lane row
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int k = 0; k < DIM; k++) begin
            a_rows[r][k] = left_ff[k*DIM + r];
         end
      end
   end

   for (genvar r = 0; r < DIM; r++) begin : g_lane
      m4cm_lane #(
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock(clock),
         .ctrl (ctrl),
         .a_row(a_rows[r]),
         .b_col(elem_arr),
         .res  (lane_res[r]),
         .clip (lane_clip[r])
      );
   end

   m4cm_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .en_out      (en_out),
      .stage_valid (v3_ff),
      .stage_column(col3_ff),
      .lane_res    (lane_res),
      .lane_clip   (lane_clip),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   a_load_writes : assert property (@(posedge clock) disable iff (reset)
      load_req |=> (left_ff[{$past(req_data.column), 2'b00}] == $past(req_data.elem0)) &&
                   (left_ff[{$past(req_data.column), 2'b11}] == $past(req_data.elem3)))
      else $error("load request did not update the left matrix column");

   a_load_no_issue : assert property (@(posedge clock) disable iff (reset)
      load_req |=> !v1_ff)
      else $error("load request entered the multiply pipeline");

   a_mult_issue : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.mode == MODE_MULTIPLY)) |=> v1_ff)
      else $error("multiply request lost at the first stage");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && v1_ff && v2_ff && v3_ff) |-> !req_ready)
      else $error("request taken while the pipeline is full and stalled");
`endif

endmodule
